>>> hw/rtl/bc3_dxt5_block_decoder_core_macros.svh
// Assertion helpers shared by the BC3 decoder RTL.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef BC3_DXT5_BLOCK_DECODER_CORE_MACROS_SVH
`define BC3_DXT5_BLOCK_DECODER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BC3_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition implies a property in the same cycle.
`define BC3_ASSERT_IMPL(lbl, cond, prop, msg) \
    `BC3_ASSERT_CLK(lbl, (cond) |-> (prop), msg)

`endif

>>> hw/rtl/bc3_pkg.sv
`default_nettype none

package bc3_pkg;

    // One color: [2] blue, [1] green, [0] red, so the packed vector is {b, g, r}.
    typedef logic [2:0][7:0] t_rgb;

    // Decoded palettes of one block plus its pixel indices.
    typedef struct packed {
        logic [7:0][7:0] apal;
        t_rgb [3:0]      cpal;
        logic [47:0]     aidx;
        logic [31:0]     cidx;
    } t_pal;

    localparam int AIDX_BITS = 3;
    localparam int CIDX_BITS = 2;
    localparam int COLS      = 4;

    // Reciprocals for truncating division, all scaled by 2^RECIP_SHIFT.
    localparam int          RECIP_SHIFT = 14;
    localparam logic [12:0] RECIP7      = 13'd2341;
    localparam logic [12:0] RECIP5      = 13'd3277;
    localparam logic [12:0] RECIP3      = 13'd5462;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [1:0] LAST_ROW     = 2'd3;

    // Widen RGB565 to 8 bits per channel by bit replication.
    function automatic t_rgb widen565(input logic [15:0] c);
        t_rgb w;
        w[0] = {c[15:11], c[15:13]};
        w[1] = {c[10:5], c[10:9]};
        w[2] = {c[4:0], c[4:2]};
        return w;
    endfunction

    // Quotient of x by the divisor with reciprocal m; exact for x < 256*divisor.
    function automatic logic [7:0] recip_div(input logic [10:0] x, input logic [12:0] m);
        logic [23:0] prod;
        prod = 24'(x) * 24'(m);
        return prod[RECIP_SHIFT + 7 : RECIP_SHIFT];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bc3_palette.sv
`default_nettype none

module bc3_palette (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [63:0]   i_alpha_block,
    input  wire logic [63:0]   i_color_block,
    output logic               o_valid,
    input  wire logic          i_take,
    output bc3_pkg::t_pal      o_pal
);
    import bc3_pkg::*;

    `include "bc3_dxt5_block_decoder_core_macros.svh"

    // Stage A: raw block
    logic        r_a_valid;
    logic [63:0] r_a_alpha;
    logic [63:0] r_a_color;

    // Stage B: endpoint modes and weighted sums
    logic             r_b_valid;
    logic             r_b_amode;
    logic [7:0]       r_b_a0;
    logic [7:0]       r_b_a1;
    logic [5:0][10:0] r_b_asum;
    logic             r_b_cmode;
    t_rgb             r_b_e0;
    t_rgb             r_b_e1;
    logic [2:0][9:0]  r_b_s2;
    logic [2:0][9:0]  r_b_s3;
    logic [47:0]      r_b_aidx;
    logic [31:0]      r_b_cidx;

    // Stage C: finished palettes
    logic r_c_valid;
    t_pal r_c_pal;

    logic             n_amode;
    logic [5:0][10:0] n_asum;
    logic             n_cmode;
    t_rgb             n_e0;
    t_rgb             n_e1;
    logic [2:0][9:0]  n_s2;
    logic [2:0][9:0]  n_s3;
    t_pal             n_pal;

    logic w_a_ready;
    logic w_b_ready;
    logic w_c_ready;

    assign w_c_ready = !r_c_valid || i_take;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_stall   = !w_a_ready;
    assign o_valid   = r_c_valid;
    assign o_pal     = r_c_pal;

    // Stage B logic: weights per entry, per-channel sums.
    always_comb begin
        logic [10:0] a0;
        logic [10:0] a1;
        logic [10:0] w0;
        logic [10:0] wk;
        a0      = {3'b000, r_a_alpha[7:0]};
        a1      = {3'b000, r_a_alpha[15:8]};
        n_amode = r_a_alpha[7:0] > r_a_alpha[15:8];
        for (int i = 0; i < 6; i++) begin
            wk = 11'(i + 1);
            if (n_amode) begin
                w0 = 11'(6 - i);
            end else if (i < 4) begin
                w0 = 11'(4 - i);
            end else begin
                w0 = 11'd0;
            end
            n_asum[i] = w0 * a0 + wk * a1;
        end
        n_cmode = r_a_color[15:0] > r_a_color[31:16];
        n_e0    = widen565(r_a_color[15:0]);
        n_e1    = widen565(r_a_color[31:16]);
        for (int ch = 0; ch < 3; ch++) begin
            n_s2[ch] = n_cmode ? ({1'b0, n_e0[ch], 1'b0} + {2'b00, n_e1[ch]})
                               : ({2'b00, n_e0[ch]} + {2'b00, n_e1[ch]});
            n_s3[ch] = {2'b00, n_e0[ch]} + {1'b0, n_e1[ch], 1'b0};
        end
    end

    // Stage C logic: reciprocal divides and palette assembly.
    always_comb begin
        logic [12:0] am;
        am = r_b_amode ? RECIP7 : RECIP5;
        n_pal.apal[0] = r_b_a0;
        n_pal.apal[1] = r_b_a1;
        for (int i = 0; i < 6; i++) begin
            if (r_b_amode || i < 4) begin
                n_pal.apal[i + 2] = recip_div(r_b_asum[i], am);
            end else if (i == 4) begin
                n_pal.apal[i + 2] = ALPHA_CLEAR;
            end else begin
                n_pal.apal[i + 2] = ALPHA_OPAQUE;
            end
        end
        n_pal.cpal[0] = r_b_e0;
        n_pal.cpal[1] = r_b_e1;
        for (int ch = 0; ch < 3; ch++) begin
            n_pal.cpal[2][ch] = r_b_cmode ? recip_div({1'b0, r_b_s2[ch]}, RECIP3)
                                          : r_b_s2[ch][8:1];
            n_pal.cpal[3][ch] = r_b_cmode ? recip_div({1'b0, r_b_s3[ch]}, RECIP3)
                                          : 8'd0;
        end
        n_pal.aidx = r_b_aidx;
        n_pal.cidx = r_b_cidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready) begin
            r_a_alpha <= i_alpha_block;
            r_a_color <= i_color_block;
        end
        if (w_b_ready) begin
            r_b_amode <= n_amode;
            r_b_a0    <= r_a_alpha[7:0];
            r_b_a1    <= r_a_alpha[15:8];
            r_b_asum  <= n_asum;
            r_b_cmode <= n_cmode;
            r_b_e0    <= n_e0;
            r_b_e1    <= n_e1;
            r_b_s2    <= n_s2;
            r_b_s3    <= n_s3;
            r_b_aidx  <= r_a_alpha[63:16];
            r_b_cidx  <= r_a_color[63:32];
        end
        if (w_c_ready) begin
            r_c_pal <= n_pal;
        end
    end

    `BC3_ASSERT_CLK(a_pal_hold, (r_c_valid && !i_take) |=> (r_c_valid && $stable(r_c_pal)), "palette stage dropped or changed a held block")
    `BC3_ASSERT_CLK(a_sum_hold, (r_b_valid && !w_c_ready) |=> (r_b_valid && $stable(r_b_asum)), "sum stage overwritten while blocked")
    `BC3_ASSERT_CLK(a_raw_hold, (r_a_valid && !w_b_ready) |=> (r_a_valid && $stable(r_a_alpha)), "input stage overwritten while blocked")

endmodule

`default_nettype wire

>>> hw/rtl/bc3_dxt5_block_decoder_core.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// block in | input     | i_valid / o_stall  | i_alpha_block[63:0], i_color_block[63:0]
// rows out | output    | o_valid / i_stall  | o_pixel_left/second/third/right[31:0],
//          |           |                    | o_row_number[1:0], o_last_row
//
// One block in becomes four row items out, top row first. The row serializer holds
// a block in the last palette stage until its last row moves into the output register.
// An accepted block passes palette stages A, B and C in turn before its first row
// loads the output register; later rows follow one per cycle while i_stall is low,
// and the palette stages can take further blocks meanwhile.
// Reset (synchronous, active low) clears every valid bit and the row counter.
// A stall on the output holds the output register; backpressure then climbs through
// the palette stages to o_stall, and no item is lost or repeated.
`default_nettype none

module bc3_dxt5_block_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [63:0] i_alpha_block,
    input  wire logic [63:0] i_color_block,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_pixel_left,
    output logic [31:0]      o_pixel_second,
    output logic [31:0]      o_pixel_third,
    output logic [31:0]      o_pixel_right,
    output logic [1:0]       o_row_number,
    output logic             o_last_row
);
    import bc3_pkg::*;

    `include "bc3_dxt5_block_decoder_core_macros.svh"

    logic w_pal_valid;
    logic w_pal_take;
    t_pal w_pal;

    // Palette build: input register, weighted sums, reciprocal divides.
    bc3_palette u_palette (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_alpha_block (i_alpha_block),
        .i_color_block (i_color_block),
        .o_valid       (w_pal_valid),
        .i_take        (w_pal_take),
        .o_pal         (w_pal)
    );

    // Row serializer and output register.
    logic        w_mid_block;
    logic [1:0]  r_row_cnt;
    logic [1:0]  n_row_cnt;
    logic        r_d_valid;
    logic [3:0][31:0] r_d_pix;
    logic [3:0][31:0] n_d_pix;
    logic [1:0]  r_d_row;

    logic w_d_ready;
    logic w_emit;

    // Load the output register when it is empty or being taken.
    assign w_d_ready   = !r_d_valid || !i_stall;
    assign w_emit      = w_pal_valid && w_d_ready;
    // Release the palette block once its last row moves out.
    assign w_pal_take  = w_emit && (r_row_cnt == LAST_ROW);
    assign n_row_cnt   = r_row_cnt + 2'd1;
    assign w_mid_block = (r_row_cnt != 2'd0);

    // Look up the four pixels of the current row.
    always_comb begin
        logic [5:0] apos;
        logic [4:0] cpos;
        logic [2:0] ai;
        logic [1:0] ci;
        for (int col = 0; col < COLS; col++) begin
            apos = 6'({r_row_cnt, 2'(col)}) * 6'(AIDX_BITS);
            cpos = 5'({r_row_cnt, 2'(col)}) * 5'(CIDX_BITS);
            ai   = w_pal.aidx[apos +: AIDX_BITS];
            ci   = w_pal.cidx[cpos +: CIDX_BITS];
            n_d_pix[col] = {w_pal.apal[ai], w_pal.cpal[ci]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= 2'd0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_row_cnt <= n_row_cnt;
            end
            if (w_d_ready) begin
                r_d_valid <= w_pal_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_d_pix <= n_d_pix;
            r_d_row <= r_row_cnt;
        end
    end

    assign o_valid        = r_d_valid;
    assign o_pixel_left   = r_d_pix[0];
    assign o_pixel_second = r_d_pix[1];
    assign o_pixel_third  = r_d_pix[2];
    assign o_pixel_right  = r_d_pix[3];
    assign o_row_number   = r_d_row;
    assign o_last_row     = (r_d_row == LAST_ROW);

    // A row counter past zero means a block is mid-serialization.
    `BC3_ASSERT_IMPL(a_row_has_block, w_mid_block, w_pal_valid, "row count with no block")
    // The counter always points at the row after the one on the output.
    `BC3_ASSERT_IMPL(a_row_order, r_d_valid, (r_row_cnt == 2'(r_d_row + 2'd1)), "row count off")
    // Every emitted row shows up on the output next cycle.
    `BC3_ASSERT_CLK(a_emit_lands, w_emit |=> (r_d_valid && (r_d_row == $past(r_row_cnt))), "row lost")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Runaway guard: far beyond the slowest legal run (about 450 blocks, four rows
    // each, with the receiver stalling 85% of the time).
    localparam int CYCLE_LIMIT = 200000;

    // One decoded row as it should leave the block: column 0 in px[0].
    typedef struct packed {
        logic [3:0][31:0] px;
        logic [1:0]       row;
        logic             last;
    } t_row_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_alpha_block;
    logic [63:0] i_color_block;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_pixel_left;
    logic [31:0] o_pixel_second;
    logic [31:0] o_pixel_third;
    logic [31:0] o_pixel_right;
    logic [1:0]  o_row_number;
    logic        o_last_row;

    t_row_item expected_rows[$];
    int        mismatch_count = 0;
    int        blocks_sent    = 0;
    int        rows_seen      = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 0;
    int        stall_pct      = 0;
    string     col_name [4]   = '{"pixel_left", "pixel_second", "pixel_third", "pixel_right"};

    bc3_dxt5_block_decoder_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_alpha_block  (i_alpha_block),
        .i_color_block  (i_color_block),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_left   (o_pixel_left),
        .o_pixel_second (o_pixel_second),
        .o_pixel_third  (o_pixel_third),
        .o_pixel_right  (o_pixel_right),
        .o_row_number   (o_row_number),
        .o_last_row     (o_last_row)
    );

    // 20 ns clock: low half, then high half.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Count cycles and give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still pending",
                     cycle_count, expected_rows.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Widen one RGB565 word to packed {blue, green, red}, 8 bits each, by
    // repeating the top bits of each channel into the new low bits.
    function automatic logic [23:0] expand565(input logic [15:0] c);
        logic [7:0] r, g, b;
        r = {c[15:11], c[15:13]};
        g = {c[10:5], c[10:9]};
        b = {c[4:0], c[4:2]};
        return {b, g, r};
    endfunction

    // Decode one compressed block and queue its four rows, top row first.
    function automatic void decode_block(input logic [63:0] ab, input logic [63:0] cb);
        int          a0, a1, k, e0, e1, row, col, p;
        logic [7:0]  apal [8];
        logic [23:0] cpal [4];
        logic [2:0]  ai;
        logic [1:0]  ci;
        t_row_item   item;
        a0 = int'(ab[7:0]);
        a1 = int'(ab[15:8]);
        apal[0] = ab[7:0];
        apal[1] = ab[15:8];
        // Eight-entry form only when a0 is strictly greater; equal endpoints
        // fall into the six-entry form with 0 and 255 at the top.
        if (a0 > a1) begin
            for (k = 1; k <= 6; k++)
                apal[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
        end else begin
            for (k = 1; k <= 4; k++)
                apal[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
            apal[6] = 8'd0;
            apal[7] = 8'd255;
        end
        cpal[0] = expand565(cb[15:0]);
        cpal[1] = expand565(cb[31:16]);
        cpal[2] = '0;
        cpal[3] = '0;
        // Compare the raw 16-bit words, not the widened colors. In the
        // three-color form entry 3 stays black.
        for (k = 0; k < 3; k++) begin
            e0 = int'(cpal[0][8*k +: 8]);
            e1 = int'(cpal[1][8*k +: 8]);
            if (cb[15:0] > cb[31:16]) begin
                cpal[2][8*k +: 8] = 8'((2 * e0 + e1) / 3);
                cpal[3][8*k +: 8] = 8'((e0 + 2 * e1) / 3);
            end else begin
                cpal[2][8*k +: 8] = 8'((e0 + e1) / 2);
            end
        end
        for (row = 0; row < 4; row++) begin
            item.row  = row[1:0];
            item.last = (row == 3);
            for (col = 0; col < 4; col++) begin
                p  = row * 4 + col;
                ai = ab[16 + 3*p +: 3];
                ci = cb[32 + 2*p +: 2];
                // Alpha never follows the black entry; it always comes from
                // the alpha palette.
                item.px[col] = {apal[ai], cpal[ci]};
            end
            expected_rows.push_back(item);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] row item %0d: %s got 0x%08h want 0x%08h",
                 $realtime, rows_seen, what, got, want);
    endtask

    // Drive one block and return once it has been taken. Valid stays high on
    // return so back-to-back blocks need no gap; an idle gap, if any, is taken
    // at the start of the next call.
    task automatic send_block(input logic [63:0] ab, input logic [63:0] cb);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid       <= 1'b0;
            i_alpha_block <= {$urandom, $urandom};
            i_color_block <= {$urandom, $urandom};
            while ($urandom_range(99) < send_idle_pct)
                @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_alpha_block <= ab;
        i_color_block <= cb;
        do
            @(posedge i_clk);
        while (o_stall);
        decode_block(ab, cb);
        blocks_sent++;
    endtask

    // Drop valid and hold off until every queued row has come out.
    task automatic wait_rows_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
    endtask

    // Alpha indices walking 0..7 across the tile, starting at index s.
    function automatic logic [47:0] alpha_ramp(input int s);
        logic [47:0] w;
        for (int p = 0; p < 16; p++)
            w[3*p +: 3] = 3'((p + s) % 8);
        return w;
    endfunction

    // Color indices walking 0..3 across the tile, starting at index s.
    function automatic logic [31:0] color_ramp(input int s);
        logic [31:0] w;
        for (int p = 0; p < 16; p++)
            w[2*p +: 2] = 2'((p + s) % 4);
        return w;
    endfunction

    // Receiver: pick the stall for the next edge at each falling edge.
    always @(negedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Check every row item taken by the receiver against the oldest prediction.
    always @(posedge i_clk) begin
        t_row_item want;
        logic [3:0][31:0] got_px;
        if (i_rst_n && o_valid && !i_stall) begin
            rows_seen++;
            got_px = {o_pixel_right, o_pixel_third, o_pixel_second, o_pixel_left};
            if (expected_rows.size() == 0) begin
                report_mismatch("row with nothing pending", got_px[0], 32'd0);
            end else begin
                want = expected_rows.pop_front();
                for (int c = 0; c < 4; c++)
                    if (got_px[c] !== want.px[c])
                        report_mismatch(col_name[c], got_px[c], want.px[c]);
                if (o_row_number !== want.row)
                    report_mismatch("row_number", 32'(o_row_number), 32'(want.row));
                if (o_last_row !== want.last)
                    report_mismatch("last_row", 32'(o_last_row), 32'(want.last));
            end
        end
    end

    // Endpoints at both ends of their ranges, all-zero and all-one words.
    task automatic test_endpoint_extremes();
        send_block(64'h0, 64'h0);
        send_block({64{1'b1}}, {64{1'b1}});
        send_block({alpha_ramp(0), 8'h00, 8'hFF}, {color_ramp(0), 16'h0000, 16'hFFFF});
        send_block({alpha_ramp(3), 8'hFF, 8'h00}, {color_ramp(1), 16'hFFFF, 16'h0000});
        send_block({alpha_ramp(5), 8'h00, 8'h01}, {color_ramp(2), 16'h0000, 16'h0001});
        send_block({alpha_ramp(6), 8'h01, 8'h00}, {color_ramp(3), 16'h0001, 16'h0000});
    endtask

    // Both alpha forms, equal endpoints included, every index in every column.
    task automatic test_alpha_forms();
        send_block({alpha_ramp(0), 8'd20, 8'd230}, {color_ramp(0), 16'h07E0, 16'hF800});
        send_block({alpha_ramp(4), 8'd20, 8'd230}, {color_ramp(2), 16'h07E0, 16'hF800});
        send_block({alpha_ramp(1), 8'd230, 8'd20}, {color_ramp(1), 16'hF800, 16'h07E0});
        send_block({alpha_ramp(7), 8'd230, 8'd20}, {color_ramp(3), 16'hF800, 16'h07E0});
        send_block({alpha_ramp(2), 8'h80, 8'h80}, {color_ramp(0), 16'h1234, 16'h5678});
        send_block({alpha_ramp(2), 8'hFF, 8'hFF}, {color_ramp(1), 16'h8421, 16'h7BDE});
    endtask

    // Four-color and three-color palettes, equal color endpoints included.
    task automatic test_color_forms();
        send_block({alpha_ramp(0), 8'd9, 8'd77}, {color_ramp(0), 16'h001F, 16'hF800});
        send_block({alpha_ramp(1), 8'd77, 8'd9}, {color_ramp(1), 16'hF800, 16'h001F});
        send_block({alpha_ramp(2), 8'd50, 8'd50}, {color_ramp(2), 16'h1234, 16'h1234});
        send_block({alpha_ramp(3), 8'd3, 8'd250}, {color_ramp(3), 16'hFFFF, 16'hFFFF});
        send_block({alpha_ramp(4), 8'd3, 8'd250}, {color_ramp(0), 16'hA5A5, 16'h5A5A});
    endtask

    // Black entry in the three-color form keeps its alpha from the palette.
    task automatic test_black_entry();
        send_block({48'h0, 8'd10, 8'd200}, {32'hFFFF_FFFF, 16'hFFFF, 16'h0000});
        send_block({{16{3'd7}}, 8'd90, 8'd40}, {32'hFFFF_FFFF, 16'h7777, 16'h7777});
        send_block({alpha_ramp(0), 8'd40, 8'd90}, {32'hFFFF_FFFF, 16'h8000, 16'h0001});
    endtask

    task automatic run_random_phase(input int count, input int idle, input int stall);
        logic [63:0] ab, cb;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < count; n++) begin
            ab = {$urandom, $urandom};
            cb = {$urandom, $urandom};
            // Bias some blocks onto the palette boundaries: equal endpoints and
            // endpoints at opposite ends of the range.
            case ($urandom_range(9))
                0: ab[15:8] = ab[7:0];
                1: cb[31:16] = cb[15:0];
                2: begin
                    ab[7:0]  = $urandom_range(1) ? 8'hFF : 8'h00;
                    ab[15:8] = ~ab[7:0];
                end
                3: begin
                    cb[15:0]  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    cb[31:16] = ~cb[15:0];
                end
                default: ;
            endcase
            send_block(ab, cb);
            // Pause halfway once, until the pipeline is empty.
            if (n == count / 2)
                wait_rows_drained();
        end
        wait_rows_drained();
    endtask

    // Random blocks through every mix of sender gaps and receiver stalls.
    task automatic test_random_traffic();
        run_random_phase(105, 0, 0);
        run_random_phase(105, 85, 0);
        run_random_phase(105, 0, 85);
        run_random_phase(105, 16, 16);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_alpha_block = '0;
        i_color_block = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_endpoint_extremes();
        test_alpha_forms();
        test_color_forms();
        test_black_entry();
        wait_rows_drained();
        test_random_traffic();

        // Let the pipeline settle so any stray row shows up.
        stall_pct = 0;
        wait_rows_drained();
        repeat (16) @(posedge i_clk);

        $display("decoded %0d blocks into %0d checked rows over %0d cycles",
                 blocks_sent, rows_seen, cycle_count);
        $display("both palette forms, black entry, gaps and stalls; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
